[src/ampvc_pkg.sv]
package ampvc_pkg;

  // Field widths of the sample and result items.
  localparam int unsigned SampleBits = 16;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CountBits  = 32;
  localparam int unsigned MeanBits   = 32;
  localparam int unsigned MagBits    = 16;
  localparam int unsigned Axes       = 3;

  // The difference between the scaled sample and the mean needs one extra bit.
  localparam int unsigned DiffBits  = MeanBits + 1;
  // One quotient bit per divider step; the root takes half as many steps as radicand bits.
  localparam int unsigned DivSteps  = DiffBits;
  localparam int unsigned RootSteps = 2 * SampleBits / 2;
  localparam int unsigned StepBits  = $clog2(DivSteps);

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StSum,
    StIter,
    StCommit,
    StSend
  } ampvc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear;
    logic prep;
    logic sum;
    logic iter;
    logic commit;
  } ampvc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic iter_last;
  } ampvc_stat_t;

endpackage

[src/ampvc_ctrl.sv]
module ampvc_ctrl
  import ampvc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        cmd_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ampvc_cmd_t  cmd_o,
  input  ampvc_stat_t stat_i
);

  ampvc_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (cmd_i) begin
            cmd_o.clear = 1'b1;
            state_d     = StSend;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = StPrep;
          end
        end
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
        state_d    = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StIter;
      end
      StIter: begin
        cmd_o.iter = 1'b1;
        if (stat_i.iter_last) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StSend;
      end
      StSend: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

[src/ampvc_dp.sv]
module ampvc_dp
  import ampvc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ampvc_cmd_t                  cmd_i,
  output ampvc_stat_t                 stat_o,
  input  logic signed [SampleBits-1:0] axis_x_i,
  input  logic signed [SampleBits-1:0] axis_y_i,
  input  logic signed [SampleBits-1:0] axis_z_i,
  output logic signed [MeanBits-1:0]  mean_x_o,
  output logic signed [MeanBits-1:0]  mean_y_o,
  output logic signed [MeanBits-1:0]  mean_z_o,
  output logic [MagBits-1:0]          peak_magnitude_o,
  output logic signed [SampleBits-1:0] peak_x_o,
  output logic signed [SampleBits-1:0] peak_y_o,
  output logic signed [SampleBits-1:0] peak_z_o,
  output logic [CountBits-1:0]        sample_total_o
);

  localparam int unsigned RadBits = 2 * SampleBits;
  localparam int unsigned SumBits = MeanBits + 3;

  // Statistics.
  logic signed [MeanBits-1:0]   mean_q [Axes];
  logic signed [SampleBits-1:0] pvec_q [Axes];
  logic [MagBits-1:0]           peak_q;
  logic [CountBits-1:0]         count_q;

  // Working registers.
  logic signed [SampleBits-1:0] samp_q [Axes];
  logic [RadBits-2:0]           sq_q   [Axes];
  logic [DiffBits-1:0]          quo_q  [Axes];
  logic [CountBits-1:0]         rem_q  [Axes];
  logic                         neg_q  [Axes];
  logic [RadBits-1:0]           rad_q, root_q, bit_q;
  logic [StepBits-1:0]          step_q;

  logic signed [DiffBits-1:0]   diff   [Axes];
  logic [DiffBits-1:0]          trial  [Axes];
  logic                         ge     [Axes];
  logic [CountBits-1:0]         rem_n  [Axes];
  logic signed [SumBits-1:0]    qsig   [Axes];
  logic signed [SumBits-1:0]    msum   [Axes];
  logic signed [MeanBits-1:0]   msat   [Axes];
  logic signed [2*SampleBits-1:0] prod [Axes];
  logic [RadBits-1:0]           rtrial;
  logic [MagBits-1:0]           mag;

  assign stat_o.iter_last = (step_q == StepBits'(DivSteps - 1));
  assign mag              = root_q[MagBits-1:0];
  assign rtrial           = root_q + bit_q;

  // Per-axis difference, divider step and saturating mean update.
  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      diff[i]  = $signed({samp_q[i][SampleBits-1], samp_q[i], {FracBits{1'b0}}})
               - $signed({mean_q[i][MeanBits-1], mean_q[i]});
      prod[i]  = samp_q[i] * samp_q[i];
      trial[i] = {rem_q[i], quo_q[i][DiffBits-1]};
      ge[i]    = trial[i] >= {1'b0, count_q};
      rem_n[i] = ge[i] ? CountBits'(trial[i] - {1'b0, count_q}) : CountBits'(trial[i]);
      qsig[i]  = neg_q[i] ? -$signed({2'b00, quo_q[i]}) : $signed({2'b00, quo_q[i]});
      msum[i]  = $signed({{(SumBits-MeanBits){mean_q[i][MeanBits-1]}}, mean_q[i]}) + qsig[i];
      if (msum[i] > $signed({{(SumBits-MeanBits+1){1'b0}}, {(MeanBits-1){1'b1}}})) begin
        msat[i] = {1'b0, {(MeanBits-1){1'b1}}};
      end else if (msum[i] < $signed({{(SumBits-MeanBits+1){1'b1}}, {(MeanBits-1){1'b0}}})) begin
        msat[i] = {1'b1, {(MeanBits-1){1'b0}}};
      end else begin
        msat[i] = msum[i][MeanBits-1:0];
      end
    end
  end

  // Statistics registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      peak_q  <= '0;
      for (int i = 0; i < Axes; i++) begin
        mean_q[i] <= '0;
        pvec_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      count_q <= '0;
      peak_q  <= '0;
      for (int i = 0; i < Axes; i++) begin
        mean_q[i] <= '0;
        pvec_q[i] <= '0;
      end
    end else if (cmd_i.prep) begin
      if (count_q != CountMax) begin
        count_q <= count_q + CountBits'(1);
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < Axes; i++) begin
        mean_q[i] <= msat[i];
      end
      if (mag > peak_q) begin
        peak_q <= mag;
        for (int i = 0; i < Axes; i++) begin
          pvec_q[i] <= samp_q[i];
        end
      end
    end
  end

  // Sample capture, squares, divider and square-root iterations.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q[0] <= axis_x_i;
      samp_q[1] <= axis_y_i;
      samp_q[2] <= axis_z_i;
    end
    if (cmd_i.prep) begin
      for (int i = 0; i < Axes; i++) begin
        sq_q[i]  <= prod[i][RadBits-2:0];
        neg_q[i] <= diff[i][DiffBits-1];
        quo_q[i] <= diff[i][DiffBits-1] ? DiffBits'(-diff[i]) : DiffBits'(diff[i]);
        rem_q[i] <= '0;
      end
    end
    if (cmd_i.sum) begin
      rad_q  <= RadBits'(sq_q[0]) + RadBits'(sq_q[1]) + RadBits'(sq_q[2]);
      root_q <= '0;
      bit_q  <= {2'b01, {(RadBits-2){1'b0}}};
      step_q <= '0;
    end
    if (cmd_i.iter) begin
      for (int i = 0; i < Axes; i++) begin
        rem_q[i] <= rem_n[i];
        quo_q[i] <= {quo_q[i][DiffBits-2:0], ge[i]};
      end
      if (step_q < StepBits'(RootSteps)) begin
        if (rad_q >= rtrial) begin
          rad_q  <= rad_q - rtrial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      step_q <= step_q + StepBits'(1);
    end
  end

  assign mean_x_o         = mean_q[0];
  assign mean_y_o         = mean_q[1];
  assign mean_z_o         = mean_q[2];
  assign peak_x_o         = pvec_q[0];
  assign peak_y_o         = pvec_q[1];
  assign peak_z_o         = pvec_q[2];
  assign peak_magnitude_o = peak_q;
  assign sample_total_o   = count_q;

`ifndef SYNTHESIS
  // A clear leaves the count and the peak at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (count_q == '0) && (peak_q == '0))
    else $error("statistics not cleared");

  // The divisor is never zero while the dividers run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.iter |-> (count_q != '0))
    else $error("zero divisor during division");

  // A partial remainder always stays below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.iter |-> (rem_q[0] < count_q))
    else $error("divider remainder out of range");
`endif

endmodule

[src/axis_mean_peak_vector_capture.sv]
// Three-axis mean and peak-magnitude capture.
//
// Input channel: in_valid_i / in_stall_o with cmd_i and axis_x_i, axis_y_i,
// axis_z_i. A transfer with cmd_i low accumulates the sample; with cmd_i high
// it clears every statistic and the sample fields are ignored.
// Output channel: out_valid_o / out_stall_i. Each input transfer gives exactly
// one output transfer holding the means (signed Q16.16), the peak magnitude and
// its sample, and the saturating sample count after that input.
// An accumulate runs from input transfer to output valid through the square,
// sum, 33 restoring divider steps and commit; a clear is presented in the
// next cycle. The 33-step divider sets the rate, and the square root runs
// alongside it. One item is worked on at a time, so the block takes no new
// item until the result of the last one has been transferred.
// While the receiver stalls, the result and the statistics hold and the input
// stays stalled. Reset zeroes all statistics and leaves the block idle.
module axis_mean_peak_vector_capture
  import ampvc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic signed [SampleBits-1:0] axis_x_i,
  input  logic signed [SampleBits-1:0] axis_y_i,
  input  logic signed [SampleBits-1:0] axis_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [MeanBits-1:0]   mean_x_o,
  output logic signed [MeanBits-1:0]   mean_y_o,
  output logic signed [MeanBits-1:0]   mean_z_o,
  output logic [MagBits-1:0]           peak_magnitude_o,
  output logic signed [SampleBits-1:0] peak_x_o,
  output logic signed [SampleBits-1:0] peak_y_o,
  output logic signed [SampleBits-1:0] peak_z_o,
  output logic [CountBits-1:0]         sample_total_o
);

  ampvc_cmd_t  cmd;
  ampvc_stat_t stat;

  // Sequencer.
  ampvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Arithmetic and statistics.
  ampvc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .axis_x_i         (axis_x_i),
    .axis_y_i         (axis_y_i),
    .axis_z_i         (axis_z_i),
    .mean_x_o         (mean_x_o),
    .mean_y_o         (mean_y_o),
    .mean_z_o         (mean_z_o),
    .peak_magnitude_o (peak_magnitude_o),
    .peak_x_o         (peak_x_o),
    .peak_y_o         (peak_y_o),
    .peak_z_o         (peak_z_o),
    .sample_total_o   (sample_total_o)
  );

endmodule

[verif/tb_axis_mean_peak_vector_capture.sv]
module tb_axis_mean_peak_vector_capture;
  import ampvc_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandItems  = 830;
  localparam int unsigned DrainWait  = 80;

  // One set of statistics as the block reports it.
  typedef struct {
    logic signed [MeanBits-1:0]   mean [Axes];
    logic [MagBits-1:0]           mag;
    logic signed [SampleBits-1:0] peak [Axes];
    logic [CountBits-1:0]         total;
  } stats_t;

  // One row of the directed sequence; known marks a result typed in by hand.
  typedef struct {
    logic                         clear;
    logic signed [SampleBits-1:0] s [Axes];
    logic                         known;
    stats_t                       res;
  } stim_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         cmd_i;
  logic signed [SampleBits-1:0] axis_x_i;
  logic signed [SampleBits-1:0] axis_y_i;
  logic signed [SampleBits-1:0] axis_z_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic signed [MeanBits-1:0]   mean_x_o;
  logic signed [MeanBits-1:0]   mean_y_o;
  logic signed [MeanBits-1:0]   mean_z_o;
  logic [MagBits-1:0]           peak_magnitude_o;
  logic signed [SampleBits-1:0] peak_x_o;
  logic signed [SampleBits-1:0] peak_y_o;
  logic signed [SampleBits-1:0] peak_z_o;
  logic [CountBits-1:0]         sample_total_o;

  axis_mean_peak_vector_capture dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .axis_x_i         (axis_x_i),
    .axis_y_i         (axis_y_i),
    .axis_z_i         (axis_z_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .mean_x_o         (mean_x_o),
    .mean_y_o         (mean_y_o),
    .mean_z_o         (mean_z_o),
    .peak_magnitude_o (peak_magnitude_o),
    .peak_x_o         (peak_x_o),
    .peak_y_o         (peak_y_o),
    .peak_z_o         (peak_z_o),
    .sample_total_o   (sample_total_o)
  );

  // Predicted statistics, kept alongside the block.
  longint unsigned     pred_count;
  longint              pred_mean [Axes];
  longint unsigned     pred_level;
  logic [SampleBits-1:0] pred_vec [Axes];

  stats_t      pending_stats [$];
  stim_row_t   directed [$];
  int unsigned mismatches;
  int unsigned sent_items;
  int unsigned clears_sent;
  int unsigned results_seen;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;

  // Clock; the single reset at the start is applied in the main sequence.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Clears the predicted statistics, as reset and the clear command do.
  function automatic void zero_stats();
    pred_count = 0;
    pred_level = 0;
    for (int i = 0; i < Axes; i++) begin
      pred_mean[i] = 0;
      pred_vec[i]  = '0;
    end
  endfunction

  // Advances the predicted statistics by one transfer and returns the result.
  function automatic stats_t mean_peak_predict(logic clear,
                                               logic signed [SampleBits-1:0] s [Axes]);
    stats_t          r;
    longint          sv;
    longint          nm;
    longint unsigned sumsq;
    longint unsigned mag;
    if (clear) begin
      zero_stats();
    end else begin
      sumsq = 0;
      if (pred_count < longint'(CountMax)) pred_count++;
      for (int i = 0; i < Axes; i++) begin
        sv = longint'(s[i]);
        nm = pred_mean[i] + ((sv <<< FracBits) - pred_mean[i]) / longint'(pred_count);
        if (nm > 64'sd2147483647) nm = 64'sd2147483647;
        if (nm < -64'sd2147483648) nm = -64'sd2147483648;
        pred_mean[i] = nm;
        sumsq += longint'(sv * sv);
      end
      mag = floor_root(sumsq);
      if (mag > 65535) mag = 65535;
      if (mag > pred_level) begin
        pred_level = mag;
        for (int i = 0; i < Axes; i++) pred_vec[i] = s[i];
      end
    end
    for (int i = 0; i < Axes; i++) begin
      r.mean[i] = pred_mean[i][MeanBits-1:0];
      r.peak[i] = pred_vec[i];
    end
    r.mag   = pred_level[MagBits-1:0];
    r.total = pred_count[CountBits-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Offers one item and waits for its transfer; the predictor runs on acceptance.
  task automatic send_sample(logic clear, logic signed [SampleBits-1:0] s [Axes],
                             logic known, stats_t typed);
    stats_t predicted;
    bit     taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = clear;
    axis_x_i   = s[0];
    axis_y_i   = s[1];
    axis_z_i   = s[2];
    taken      = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    predicted = mean_peak_predict(clear, s);
    pending_stats.push_back(known ? typed : predicted);
    sent_items++;
    if (clear) clears_sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_sender();
    in_valid_i = 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [SampleBits-1:0] rand_axis();
    case ($urandom_range(7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return SampleBits'($signed($urandom_range(0, 8)) - 4);
      3:       return SampleBits'($signed($urandom_range(0, 600)) - 300);
      default: return SampleBits'($urandom);
    endcase
  endfunction

  function automatic void add_row(logic clear, int x, int y, int z);
    stim_row_t r;
    r.clear = clear;
    r.s[0]  = SampleBits'(x);
    r.s[1]  = SampleBits'(y);
    r.s[2]  = SampleBits'(z);
    r.known = 1'b0;
    directed.push_back(r);
  endfunction

  // Adds a row whose result is plain: means at the sample (zero for a clear), peak at the sample (zero when m is zero).
  function automatic void add_known(logic clear, int x, int y, int z, int m, int n);
    stim_row_t r;
    r.clear = clear;
    r.s[0]  = SampleBits'(x);
    r.s[1]  = SampleBits'(y);
    r.s[2]  = SampleBits'(z);
    r.known = 1'b1;
    for (int i = 0; i < Axes; i++) begin
      r.res.mean[i] = clear ? '0 : MeanBits'(longint'(r.s[i]) <<< FracBits);
      r.res.peak[i] = (m == 0) ? '0 : r.s[i];
    end
    r.res.mag   = MagBits'(m);
    r.res.total = CountBits'(n);
    directed.push_back(r);
  endfunction

  // Receiver side: random stall, or a long hold-off when one is asked for.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      out_stall_i <= 1'b1;
      hold_request <= hold_request - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Checks each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        $display("UNEXPECTED result transfer with nothing outstanding");
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        if (mean_x_o !== want.mean[0]) report_mismatch("mean_x", mean_x_o, want.mean[0]);
        if (mean_y_o !== want.mean[1]) report_mismatch("mean_y", mean_y_o, want.mean[1]);
        if (mean_z_o !== want.mean[2]) report_mismatch("mean_z", mean_z_o, want.mean[2]);
        if (peak_magnitude_o !== want.mag)
          report_mismatch("peak_magnitude", peak_magnitude_o, want.mag);
        if (peak_x_o !== want.peak[0]) report_mismatch("peak_x", peak_x_o, want.peak[0]);
        if (peak_y_o !== want.peak[1]) report_mismatch("peak_y", peak_y_o, want.peak[1]);
        if (peak_z_o !== want.peak[2]) report_mismatch("peak_z", peak_z_o, want.peak[2]);
        if (sample_total_o !== want.total)
          report_mismatch("sample_total", sample_total_o, want.total);
      end
      results_seen++;
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_stats.size());
      $display("tb_axis_mean_peak_vector_capture: errors");
      $finish;
    end
  end

  initial begin
    logic signed [SampleBits-1:0] s [Axes];
    stats_t                       none;
    int unsigned                  drain;
    in_valid_i    = 1'b0;
    cmd_i         = 1'b0;
    axis_x_i      = '0;
    axis_y_i      = '0;
    axis_z_i      = '0;
    out_stall_i   = 1'b0;
    mismatches    = 0;
    sent_items    = 0;
    clears_sent   = 0;
    results_seen  = 0;
    cycles        = 0;
    hold_request  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    zero_stats();
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: extremes, clear with junk fields, peak tie, zero sample.
    add_known(1'b1, 0, 0, 0, 0, 0);
    add_known(1'b0, -32768, -32768, -32768, 56755, 1);
    add_row(1'b0, 32767, 32767, 32767);
    add_row(1'b0, -32768, -32768, -32768);
    add_known(1'b1, -1, 21845, -21846, 0, 0);
    add_known(1'b0, 0, 0, 0, 0, 1);
    add_row(1'b0, 32767, 0, 0);
    add_row(1'b0, 0, -32768, 0);
    add_row(1'b0, 0, 0, 32767);
    add_row(1'b0, -1, -1, -1);
    add_row(1'b0, 1, 2, 2);
    add_known(1'b1, 32767, 32767, 32767, 0, 0);
    add_known(1'b0, 1, 2, 2, 3, 1);
    add_row(1'b0, 2, 1, -2);
    add_row(1'b0, -2, -2, 1);
    add_row(1'b0, 12345, -2345, 345);
    add_row(1'b0, 32767, -32768, 32767);
    add_row(1'b0, -7, 3, 0);
    foreach (directed[i])
      send_sample(directed[i].clear, directed[i].s, directed[i].known, directed[i].res);

    // Random part in three idling phases, with a long receiver hold-off and a
    // full drain between phases.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 29 : 0;
      for (int n = 0; n < RandItems / 3; n++) begin
        if (n == 40) hold_request = 400;
        for (int i = 0; i < Axes; i++) s[i] = rand_axis();
        if ($urandom_range(99) < 8 && n > 0) begin
          // Repeat the peak sample to land on an equal magnitude.
          for (int i = 0; i < Axes; i++) s[i] = pred_vec[i];
        end
        send_sample($urandom_range(99) < 3, s, 1'b0, none);
      end
      idle_sender();
      while (pending_stats.size() != 0) @(negedge clk_i);
      repeat (DrainWait) @(negedge clk_i);
    end

    drain = 0;
    while (pending_stats.size() != 0 && drain < 10000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (DrainWait) @(negedge clk_i);

    $display("Sent %0d items (%0d clears) under three idling patterns, %0d results checked.",
             sent_items, clears_sent, results_seen);
    $display("Included full-scale samples, peak ties and a 400-cycle receiver hold-off.");
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("tb_axis_mean_peak_vector_capture: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending_stats.size());
      $display("tb_axis_mean_peak_vector_capture: errors");
    end
    $finish;
  end

endmodule
